### design/srxu_pkg.sv
package srxu_pkg;

	localparam logic [7:0] START_MARK = 8'hAA;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ID,
		PH_LEN,
		PH_DATA,
		PH_SUM
	} phase_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	typedef struct packed {
		logic       avail;
		logic       bank;
		logic [1:0] count;
	} queue_stat_t;

	typedef struct packed {
		logic busy;
		logic bank;
	} back_stat_t;

endpackage

### design/srxu_ram.sv
module srxu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/srxu_queue.sv
module srxu_queue
	import srxu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        push_bank,
	input  logic        pop,
	output queue_stat_t stat
);

	logic       ent_q [QUEUE_DEPTH];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_bank;
		end
	end

	always_comb begin
		stat.avail = (cnt_q != 2'd0);
		stat.bank  = ent_q[rp_q];
		stat.count = cnt_q;
	end

endmodule

### design/srxu_front.sv
module srxu_front
	import srxu_pkg::*;
#(
	parameter int WORD_COUNT = 8,
	localparam int FB = 2 * WORD_COUNT,
	localparam int CW = $clog2(FB + 1),
	localparam int AW = $clog2(FB)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    node_addr,
	input  logic          bufs_full,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [15:0]   ram_wdata,
	output logic          push,
	output logic          push_bank
);

	phase_t          phase_q, phase_d;
	logic [CW-1:0]   cnt_q;
	logic [7:0]      xor_q;
	logic [7:0]      hi_q;
	logic            bank_q;
	logic            acc;
	logic [AW-1:0]   widx;

	assign acc = s_tvalid && s_tready;
	assign widx = AW'(cnt_q >> 1);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (acc && rx_byte == START_MARK) phase_d = PH_ID;
			end
			PH_ID: begin
				if (acc) phase_d = (rx_byte == node_addr) ? PH_LEN : PH_HUNT;
			end
			PH_LEN: begin
				if (acc) phase_d = (rx_byte == 8'(FB)) ? PH_DATA : PH_HUNT;
			end
			PH_DATA: begin
				if (acc && cnt_q == CW'(FB - 1)) phase_d = PH_SUM;
			end
			PH_SUM: begin
				if (acc) phase_d = PH_HUNT;
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_comb begin
		s_tready  = !(phase_q == PH_DATA && bufs_full);
		ram_we    = acc && phase_q == PH_DATA && cnt_q[0];
		ram_waddr = bank_q ? AW'(WORD_COUNT) + widx : widx;
		ram_wdata = {hi_q, rx_byte};
		push      = acc && phase_q == PH_SUM && xor_q == rx_byte;
		push_bank = bank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			xor_q   <= 8'd0;
			bank_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (acc) begin
				unique case (phase_q)
					PH_ID:   xor_q <= rx_byte;
					PH_LEN: begin
						xor_q <= xor_q ^ rx_byte;
						cnt_q <= '0;
					end
					PH_DATA: begin
						xor_q <= xor_q ^ rx_byte;
						cnt_q <= cnt_q + CW'(1);
					end
					default: ;
				endcase
			end
			if (push) begin
				bank_q <= ~bank_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_DATA && !cnt_q[0]) begin
			hi_q <= rx_byte;
		end
	end

endmodule

### design/srxu_back.sv
module srxu_back
	import srxu_pkg::*;
#(
	parameter int WORD_COUNT = 8,
	localparam int FB = 2 * WORD_COUNT,
	localparam int AW = $clog2(FB),
	localparam int IW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_stat_t   q_stat,
	output logic          pop,
	output logic          ram_re,
	output logic [AW-1:0] ram_raddr,
	input  logic [15:0]   ram_rdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [23:0]   m_tdata,
	output logic          m_tlast,
	output back_stat_t    stat
);

	back_state_t        state_q, state_d;
	logic               bank_q;
	logic [IW-1:0]      idx_q;
	logic               pend_q;
	logic [IW-1:0]      idx_s1;
	logic               last_s1;
	logic               ov_q;
	logic [2:0]         oidx_q;
	logic signed [15:0] oval_q;
	logic               olast_q;
	logic               issue;
	logic               at_last;

	assign at_last = (idx_q == IW'(WORD_COUNT - 1));
	assign issue   = state_q == BK_RUN && !pend_q && (!ov_q || m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (q_stat.avail) state_d = BK_RUN;
			BK_RUN:  if (issue && at_last) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = state_q == BK_IDLE && q_stat.avail;
		ram_re    = issue;
		ram_raddr = bank_q ? AW'(WORD_COUNT) + AW'(idx_q) : AW'(idx_q);
		stat.busy = state_q == BK_RUN;
		stat.bank = bank_q;
		m_tvalid  = ov_q;
		m_tdata   = {5'd0, oval_q, oidx_q};
		m_tlast   = olast_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			bank_q  <= 1'b0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= issue;
			if (pop) begin
				bank_q <= q_stat.bank;
				idx_q  <= '0;
			end else if (issue) begin
				idx_q <= idx_q + IW'(1);
			end
			if (pend_q) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= idx_q;
			last_s1 <= at_last;
		end
		if (pend_q) begin
			oidx_q  <= 3'(idx_s1);
			oval_q  <= ram_rdata;
			olast_q <= last_s1;
		end
	end

endmodule

### design/serial_frame_receiver_xor_unit.sv
// serial frame receiver with xor checksum
// s_* channel: one received byte per request, s_tdata[7:0] = rx_byte.
// frames are [0xaa][id][length][data...][checksum]; id must match node_addr,
// length must be 2*WORD_COUNT, and the xor of id, length and data must equal
// the checksum, otherwise the frame is dropped without any output.
// m_* channel: WORD_COUNT requests per good frame, big-endian signed words,
// m_tlast on the final word.
// input takes one byte per cycle while s_tready is high. words pass the
// registered read of the two-bank frame buffer feeding the output register;
// a word's read waits until the previous word reaches the output register.
// frames are held in two banks with a two-entry queue of finished frames, so
// the next frame's bytes arrive while the previous one drains. if both
// banks are still held, s_tready drops on data bytes until a bank frees.
// a stalled m_tready only holds the output word; header bytes keep flowing.
// reset clears the parser to hunting, empties the queue, drops m_tvalid and
// sets node_addr to 1. cfg_we writes node_addr from cfg_wdata.
module serial_frame_receiver_xor_unit
	import srxu_pkg::*;
#(
	parameter int WORD_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,    // node_addr
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,      // word_index[2:0], word_value[18:3]
	output logic        m_tlast       // last_word
);

	localparam int FB = 2 * WORD_COUNT;
	localparam int AW = $clog2(FB);

	logic [7:0]    node_addr_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;
	logic          push;
	logic          push_bank;
	logic          pop;
	logic          bufs_full;
	queue_stat_t   q_stat;
	back_stat_t    bk_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_addr_q <= 8'd1;
		end else if (cfg_we) begin
			node_addr_q <= cfg_wdata;
		end
	end

	assign bufs_full = (3'(q_stat.count) + 3'(bk_stat.busy)) >= 3'(QUEUE_DEPTH);

	srxu_front #(.WORD_COUNT(WORD_COUNT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.rx_byte   (s_tdata),
		.node_addr (node_addr_q),
		.bufs_full (bufs_full),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.push      (push),
		.push_bank (push_bank)
	);

	srxu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_bank (push_bank),
		.pop       (pop),
		.stat      (q_stat)
	);

	srxu_ram #(.WIDTH(16), .DEPTH(FB)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srxu_back #(.WORD_COUNT(WORD_COUNT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop       (pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.stat      (bk_stat)
	);

	// never overwrite the bank being drained
	a_bank_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && bk_stat.busy) |-> ((ram_waddr >= AW'(WORD_COUNT)) != bk_stat.bank))
		else $error("write into bank being drained");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_stat.count < 2'(QUEUE_DEPTH)))
		else $error("frame queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.count != 2'd0)
		else $error("frame queue underflow");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[2:0] == 3'(WORD_COUNT - 1)))
		else $error("last word with wrong index");

endmodule
